/* rtl/core/smpt_pkg.sv */
package smpt_pkg;

  // table sizes
  localparam int SHORT_SLOTS = 16;
  localparam int EXT_SLOTS   = 16;
  localparam int MAX_SLOTS   = (SHORT_SLOTS > EXT_SLOTS) ? SHORT_SLOTS : EXT_SLOTS;

  // slot index widths (at least one bit)
  localparam int SHORT_IDX_W = (SHORT_SLOTS > 1) ? $clog2(SHORT_SLOTS) : 1;
  localparam int EXT_IDX_W   = (EXT_SLOTS > 1) ? $clog2(EXT_SLOTS) : 1;
  localparam int WALK_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  localparam logic [WALK_W-1:0] SHORT_LAST = WALK_W'(SHORT_SLOTS - 1);
  localparam logic [WALK_W-1:0] EXT_LAST   = WALK_W'(EXT_SLOTS - 1);

  // configuration register indexes
  localparam logic CFG_PAN_ID       = 1'b0;
  localparam logic CFG_MATCH_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD_SHORT       = 3'd0,
    OP_ADD_EXT         = 3'd1,
    OP_CLEAR_SHORT     = 3'd2,
    OP_CLEAR_EXT       = 3'd3,
    OP_CLEAR_ALL_SHORT = 3'd4,
    OP_CLEAR_ALL_EXT   = 3'd5,
    OP_DATA_REQUEST    = 3'd6
  } op_t;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_SHORT = 2'd1;
  localparam logic [1:0] SRC_LONG  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] short_address;
    logic [63:0] ext_address;
    logic [1:0]  source_mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       frame_pending;
    logic [3:0] slot;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_walk;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/smpt_ctrl.sv */
module smpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  smpt_pkg::stat_t stat,
  output smpt_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.need_walk ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.hit || stat.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_CALC)
    else $error("accepted item did not start tag calculation");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && (stat.hit || stat.last)) |=> state == S_FINISH)
    else $error("walk did not stop at hit or last slot");

  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && stat.out_free) |=> state == S_IDLE)
    else $error("result not handed to output register");

endmodule

/* rtl/core/smpt_datapath.sv */
module smpt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  smpt_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  smpt_pkg::cmd_t      cmd,
  output smpt_pkg::stat_t     stat,
  output logic                out_valid,
  input  logic                out_stall,
  output smpt_pkg::out_item_t out_item
);

  localparam int SHORT_SLOTS_DEPTH = smpt_pkg::SHORT_SLOTS;
  localparam int EXT_SLOTS_DEPTH   = smpt_pkg::EXT_SLOTS;

  // configuration
  logic [15:0] pan_id;
  logic        match_enable;

  // latched item and search key
  smpt_pkg::in_item_t item;
  logic [15:0]        key;
  logic [smpt_pkg::WALK_W-1:0] cnt;

  // tables
  logic [15:0] short_tags [SHORT_SLOTS_DEPTH];
  logic [15:0] ext_tags   [EXT_SLOTS_DEPTH];
  logic [smpt_pkg::SHORT_SLOTS-1:0] short_valid;
  logic [smpt_pkg::EXT_SLOTS-1:0]   ext_valid;

  // pending result
  logic [1:0] res_status;
  logic       res_pending;
  logic [3:0] res_slot;

  // decode
  logic is_add;
  logic is_clear;
  logic is_req;
  logic use_ext;
  logic [15:0] key_next;
  logic [smpt_pkg::SHORT_IDX_W-1:0] short_idx;
  logic [smpt_pkg::EXT_IDX_W-1:0]   ext_idx;
  logic        cur_valid;
  logic [15:0] cur_tag;
  logic        hit;
  logic        last;

  always_comb begin
    is_add   = (item.opcode == smpt_pkg::OP_ADD_SHORT) ||
               (item.opcode == smpt_pkg::OP_ADD_EXT);
    is_clear = (item.opcode == smpt_pkg::OP_CLEAR_SHORT) ||
               (item.opcode == smpt_pkg::OP_CLEAR_EXT);
    is_req   = (item.opcode == smpt_pkg::OP_DATA_REQUEST);
    use_ext  = (item.opcode == smpt_pkg::OP_ADD_EXT) ||
               (item.opcode == smpt_pkg::OP_CLEAR_EXT) ||
               (is_req && item.source_mode == smpt_pkg::SRC_LONG);
  end

  // tag of the latched item, modulo 2^16
  always_comb begin
    if (use_ext) begin
      key_next = pan_id + item.ext_address[15:0] + item.ext_address[31:16] +
                 item.ext_address[47:32] + item.ext_address[63:48];
    end else begin
      key_next = pan_id + item.short_address;
    end
  end

  // slot under inspection
  always_comb begin
    short_idx = cnt[smpt_pkg::SHORT_IDX_W-1:0];
    ext_idx   = cnt[smpt_pkg::EXT_IDX_W-1:0];
    cur_valid = use_ext ? ext_valid[ext_idx] : short_valid[short_idx];
    cur_tag   = use_ext ? ext_tags[ext_idx] : short_tags[short_idx];
    hit       = is_add ? !cur_valid : (cur_valid && cur_tag == key);
    last      = (cnt == (use_ext ? smpt_pkg::EXT_LAST : smpt_pkg::SHORT_LAST));
  end

  always_comb begin
    stat.need_walk = is_add || is_clear ||
                     (is_req && match_enable &&
                      (item.source_mode == smpt_pkg::SRC_SHORT ||
                       item.source_mode == smpt_pkg::SRC_LONG));
    stat.hit       = hit;
    stat.last      = last;
    stat.out_free  = !out_valid || !out_stall;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_id       <= '0;
      match_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        smpt_pkg::CFG_PAN_ID:       pan_id       <= cfg_data;
        smpt_pkg::CFG_MATCH_ENABLE: match_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item, key, walk counter and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (cmd.calc) begin
      key         <= key_next;
      cnt         <= '0;
      res_status  <= smpt_pkg::ST_OK;
      res_pending <= is_req && !match_enable;
      res_slot    <= '0;
    end else if (cmd.step) begin
      if (hit) begin
        res_slot <= 4'(cnt);
        if (is_req) begin
          res_pending <= 1'b1;
        end
      end else if (last) begin
        if (is_add) begin
          res_status <= smpt_pkg::ST_FULL;
        end else if (is_clear) begin
          res_status <= smpt_pkg::ST_NOT_FOUND;
        end
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // tag stores
  always_ff @(posedge clk) begin
    if (cmd.step && hit && (is_add || is_clear)) begin
      if (use_ext) begin
        ext_tags[ext_idx] <= is_add ? key : 16'd0;
      end else begin
        short_tags[short_idx] <= is_add ? key : 16'd0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      short_valid <= '0;
      ext_valid   <= '0;
    end else if (cmd.calc && item.opcode == smpt_pkg::OP_CLEAR_ALL_SHORT) begin
      short_valid <= '0;
    end else if (cmd.calc && item.opcode == smpt_pkg::OP_CLEAR_ALL_EXT) begin
      ext_valid <= '0;
    end else if (cmd.step && hit && (is_add || is_clear)) begin
      if (use_ext) begin
        ext_valid[ext_idx] <= is_add;
      end else begin
        short_valid[short_idx] <= is_add;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.status        <= res_status;
      out_item.frame_pending <= res_pending;
      out_item.slot          <= res_slot;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_add_short_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && hit && item.opcode == smpt_pkg::OP_ADD_SHORT) |=>
    $countones(short_valid) == $past($countones(short_valid)) + 1)
    else $error("short add did not occupy a free slot");

  a_clear_ext_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && hit && item.opcode == smpt_pkg::OP_CLEAR_EXT) |=>
    $countones(ext_valid) + 1 == $past($countones(ext_valid)))
    else $error("ext clear did not free a slot");

endmodule

/* rtl/core/source_match_pending_table.sv */
// Source address match table with frame-pending answer.
// Input channel: in_valid / in_stall carry one command item (opcode,
// addresses, source mode); it is taken at an edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall return exactly one
// result item (status, frame_pending, slot) per command, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 PAN id, 1 match enable); write only while no command is in flight.
// Steps: the CALC state computes the 16-bit tag, then the selected table is
// walked one slot per cycle until the first hit or the last slot, then the
// FINISH state moves the result into the output register. Clear-all and
// direct data requests skip the walk; adds, clears and searched data
// requests walk up to 16 slots. One command is in work at a time.
// The next command is accepted while a result still waits in the output
// register; if out_stall holds that register, a finished walk waits for it.
// Reset (rst, synchronous) empties both tables, clears PAN id and match
// enable, and leaves both channels idle.
module source_match_pending_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smpt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output smpt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  smpt_pkg::cmd_t  cmd;
  smpt_pkg::stat_t stat;

  // sequencer
  smpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, key and output register
  smpt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/source_match_pending_table_test.sv */
`timescale 1ns / 1ps

module source_match_pending_table_test;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam logic [1:0] SRC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HIST_DEPTH = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  smpt_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  smpt_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic                cfg_index = smpt_pkg::CFG_PAN_ID;
  logic [15:0]         cfg_data = '0;

  source_match_pending_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the tables and registers
  logic [15:0] short_tag_mem [smpt_pkg::SHORT_SLOTS];
  logic        short_used    [smpt_pkg::SHORT_SLOTS];
  logic [15:0] ext_tag_mem   [smpt_pkg::EXT_SLOTS];
  logic        ext_used      [smpt_pkg::EXT_SLOTS];
  logic [15:0] pan_q = '0;
  logic        match_en_q = 1'b0;

  smpt_pkg::out_item_t answer_q [$];
  logic [15:0] short_hist [$];
  logic [63:0] ext_hist [$];

  int idle_pct = 29;
  int stall_pct = 29;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int n_full = 0;
  int n_not_found = 0;
  int n_pending = 0;
  int n_hits = 0;
  int quiet_cycles = 0;

  initial begin
    foreach (short_used[i]) begin
      short_used[i] = 1'b0;
      short_tag_mem[i] = '0;
    end
    foreach (ext_used[i]) begin
      ext_used[i] = 1'b0;
      ext_tag_mem[i] = '0;
    end
  end

  function automatic logic [15:0] short_tag(input logic [15:0] addr);
    return addr + pan_q;
  endfunction

  function automatic logic [15:0] ext_tag(input logic [63:0] addr);
    return pan_q + addr[15:0] + addr[31:16] + addr[47:32] + addr[63:48];
  endfunction

  // Apply one command to the shadow tables and return the answer it must produce.
  function automatic smpt_pkg::out_item_t apply_command(input smpt_pkg::in_item_t it);
    smpt_pkg::out_item_t r;
    int s;
    logic [15:0] tag;
    r = '0;
    r.status = smpt_pkg::ST_OK;
    s = -1;
    case (it.opcode)
      smpt_pkg::OP_ADD_SHORT: begin
        for (int i = smpt_pkg::SHORT_SLOTS - 1; i >= 0; i--) if (!short_used[i]) s = i;
        if (s < 0) begin
          r.status = smpt_pkg::ST_FULL;
        end else begin
          short_tag_mem[s] = short_tag(it.short_address);
          short_used[s] = 1'b1;
          r.slot = 4'(s);
        end
      end
      smpt_pkg::OP_ADD_EXT: begin
        for (int i = smpt_pkg::EXT_SLOTS - 1; i >= 0; i--) if (!ext_used[i]) s = i;
        if (s < 0) begin
          r.status = smpt_pkg::ST_FULL;
        end else begin
          ext_tag_mem[s] = ext_tag(it.ext_address);
          ext_used[s] = 1'b1;
          r.slot = 4'(s);
        end
      end
      smpt_pkg::OP_CLEAR_SHORT: begin
        tag = short_tag(it.short_address);
        for (int i = smpt_pkg::SHORT_SLOTS - 1; i >= 0; i--)
          if (short_used[i] && short_tag_mem[i] == tag) s = i;
        if (s < 0) begin
          r.status = smpt_pkg::ST_NOT_FOUND;
        end else begin
          short_tag_mem[s] = '0;
          short_used[s] = 1'b0;
          r.slot = 4'(s);
        end
      end
      smpt_pkg::OP_CLEAR_EXT: begin
        tag = ext_tag(it.ext_address);
        for (int i = smpt_pkg::EXT_SLOTS - 1; i >= 0; i--)
          if (ext_used[i] && ext_tag_mem[i] == tag) s = i;
        if (s < 0) begin
          r.status = smpt_pkg::ST_NOT_FOUND;
        end else begin
          ext_tag_mem[s] = '0;
          ext_used[s] = 1'b0;
          r.slot = 4'(s);
        end
      end
      smpt_pkg::OP_CLEAR_ALL_SHORT: begin
        foreach (short_used[i]) begin
          short_used[i] = 1'b0;
          short_tag_mem[i] = '0;
        end
      end
      smpt_pkg::OP_CLEAR_ALL_EXT: begin
        foreach (ext_used[i]) begin
          ext_used[i] = 1'b0;
          ext_tag_mem[i] = '0;
        end
      end
      smpt_pkg::OP_DATA_REQUEST: begin
        if (!match_en_q) begin
          r.frame_pending = 1'b1;
        end else if (it.source_mode == smpt_pkg::SRC_SHORT) begin
          tag = short_tag(it.short_address);
          for (int i = smpt_pkg::SHORT_SLOTS - 1; i >= 0; i--)
            if (short_used[i] && short_tag_mem[i] == tag) s = i;
        end else if (it.source_mode == smpt_pkg::SRC_LONG) begin
          tag = ext_tag(it.ext_address);
          for (int i = smpt_pkg::EXT_SLOTS - 1; i >= 0; i--)
            if (ext_used[i] && ext_tag_mem[i] == tag) s = i;
        end
        if (s >= 0) begin
          r.frame_pending = 1'b1;
          r.slot = 4'(s);
          n_hits++;
        end
      end
      default: ;
    endcase
    if (r.status == smpt_pkg::ST_FULL) n_full++;
    if (r.status == smpt_pkg::ST_NOT_FOUND) n_not_found++;
    if (r.frame_pending) n_pending++;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Send one command item; leaves in_valid high so back-to-back items need no gap.
  task automatic send_item(input smpt_pkg::in_item_t it);
    bit taken;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    answer_q.push_back(apply_command(it));
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding answer.
  task automatic drain;
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers, block idle.
  task automatic set_config(input logic [15:0] pan, input logic en);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= smpt_pkg::CFG_PAN_ID;
    cfg_data  <= pan;
    @(posedge clk);
    pan_q = pan;
    cfg_index <= smpt_pkg::CFG_MATCH_ENABLE;
    cfg_data  <= {15'd0, en};
    @(posedge clk);
    match_en_q = en;
    cfg_we <= 1'b0;
  endtask

  function automatic smpt_pkg::in_item_t make_item(input logic [2:0] op,
                                                   input logic [15:0] sa,
                                                   input logic [63:0] ea,
                                                   input logic [1:0] mode);
    smpt_pkg::in_item_t it;
    it.opcode        = op;
    it.short_address = sa;
    it.ext_address   = ea;
    it.source_mode   = mode;
    return it;
  endfunction

  // Random command, biased toward addresses already placed in the tables.
  function automatic smpt_pkg::in_item_t random_item();
    smpt_pkg::in_item_t it;
    int pick;
    logic [63:0] ea;
    it = make_item(3'($urandom_range(7)), 16'($urandom), {$urandom, $urandom},
                   2'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 20)      it.opcode = smpt_pkg::OP_ADD_SHORT;
    else if (pick < 40) it.opcode = smpt_pkg::OP_ADD_EXT;
    else if (pick < 55) it.opcode = smpt_pkg::OP_CLEAR_SHORT;
    else if (pick < 70) it.opcode = smpt_pkg::OP_CLEAR_EXT;
    else if (pick < 73) it.opcode = smpt_pkg::OP_CLEAR_ALL_SHORT;
    else if (pick < 76) it.opcode = smpt_pkg::OP_CLEAR_ALL_EXT;
    else if (pick < 98) it.opcode = smpt_pkg::OP_DATA_REQUEST;
    else                it.opcode = OP_UNUSED;
    if (it.opcode == smpt_pkg::OP_DATA_REQUEST) begin
      pick = $urandom_range(99);
      if (pick < 45)      it.source_mode = smpt_pkg::SRC_SHORT;
      else if (pick < 90) it.source_mode = smpt_pkg::SRC_LONG;
      else if (pick < 95) it.source_mode = smpt_pkg::SRC_NONE;
      else                it.source_mode = SRC_UNUSED;
    end
    if ($urandom_range(9) < 7) begin
      if (short_hist.size() != 0)
        it.short_address = short_hist[$urandom_range(short_hist.size() - 1)];
      if (ext_hist.size() != 0) begin
        ea = ext_hist[$urandom_range(ext_hist.size() - 1)];
        // same tag reached through reordered words
        if ($urandom_range(3) == 0) ea = {ea[15:0], ea[63:16]};
        it.ext_address = ea;
      end
    end
    if (it.opcode == smpt_pkg::OP_ADD_SHORT) begin
      short_hist.push_back(it.short_address);
      if (short_hist.size() > HIST_DEPTH) void'(short_hist.pop_front());
    end
    if (it.opcode == smpt_pkg::OP_ADD_EXT) begin
      ext_hist.push_back(it.ext_address);
      if (ext_hist.size() > HIST_DEPTH) void'(ext_hist.pop_front());
    end
    return it;
  endfunction

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checker: sampled mid-cycle, taken at the next rising edge
  always @(negedge clk) begin
    smpt_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d pending=%0d slot=%0d",
                                  out_item.status, out_item.frame_pending, out_item.slot));
      end else begin
        want = answer_q.pop_front();
        results_seen++;
        if (out_item.status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, out_item.status, want.status));
        if (out_item.frame_pending !== want.frame_pending)
          report_mismatch($sformatf("result %0d frame_pending got %0d want %0d",
                                    results_seen, out_item.frame_pending, want.frame_pending));
        if (out_item.slot !== want.slot)
          report_mismatch($sformatf("result %0d slot got %0d want %0d",
                                    results_seen, out_item.slot, want.slot));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Registers at reset value: matching off, so every request is pending.
  task automatic test_reset_defaults;
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'h0000, 64'd0, smpt_pkg::SRC_SHORT));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'hFFFF, '1, SRC_UNUSED));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'h1234, 64'd5, smpt_pkg::SRC_LONG));
  endtask

  task automatic test_directed_ops;
    set_config(16'h1234, 1'b1);
    send_item(make_item(smpt_pkg::OP_ADD_SHORT, 16'h0000, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_ADD_SHORT, 16'hFFFF, '1, SRC_UNUSED));
    send_item(make_item(smpt_pkg::OP_ADD_EXT, 16'h0000, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_ADD_EXT, 16'hFFFF, '1, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_ADD_EXT, 16'h0, 64'h0123_4567_89AB_CDEF,
                        smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'hFFFF, 64'd0, smpt_pkg::SRC_SHORT));
    // word order differs, tag is the same
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'h0, 64'hCDEF_89AB_4567_0123,
                        smpt_pkg::SRC_LONG));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'hFFFF, '1, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'hFFFF, '1, SRC_UNUSED));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'h5555, 64'd7, smpt_pkg::SRC_SHORT));
    send_item(make_item(smpt_pkg::OP_CLEAR_SHORT, 16'h0000, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_CLEAR_SHORT, 16'h0000, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_ADD_SHORT, 16'hABCD, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_CLEAR_EXT, 16'h0, '1, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_CLEAR_EXT, 16'h0, 64'hDEAD_BEEF_0000_0001,
                        smpt_pkg::SRC_NONE));
    send_item(make_item(OP_UNUSED, 16'hFFFF, '1, SRC_UNUSED));
    send_item(make_item(smpt_pkg::OP_ADD_SHORT, 16'h0042, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_ADD_SHORT, 16'h0042, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_CLEAR_SHORT, 16'h0042, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_CLEAR_ALL_SHORT, 16'h0, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'hFFFF, 64'd0, smpt_pkg::SRC_SHORT));
    send_item(make_item(smpt_pkg::OP_CLEAR_ALL_EXT, 16'h0, 64'd0, smpt_pkg::SRC_NONE));
    send_item(make_item(smpt_pkg::OP_DATA_REQUEST, 16'h0, 64'd0, smpt_pkg::SRC_LONG));
  endtask

  // Fill both tables past capacity, then search and clear through them.
  task automatic test_fill_tables;
    logic [15:0] sa;
    logic [63:0] ea;
    set_config(16'($urandom), 1'b1);
    for (int i = 0; i <= smpt_pkg::SHORT_SLOTS; i++) begin
      sa = 16'($urandom);
      short_hist.push_back(sa);
      send_item(make_item(smpt_pkg::OP_ADD_SHORT, sa, {$urandom, $urandom},
                          smpt_pkg::SRC_NONE));
    end
    for (int i = 0; i <= smpt_pkg::EXT_SLOTS; i++) begin
      ea = {$urandom, $urandom};
      ext_hist.push_back(ea);
      send_item(make_item(smpt_pkg::OP_ADD_EXT, 16'($urandom), ea, smpt_pkg::SRC_NONE));
    end
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(smpt_pkg::OP_DATA_REQUEST,
                          short_hist[$urandom_range(short_hist.size() - 1)],
                          ext_hist[$urandom_range(ext_hist.size() - 1)],
                          ($urandom_range(1) != 0) ? smpt_pkg::SRC_SHORT
                                                   : smpt_pkg::SRC_LONG));
    end
    for (int i = 0; i < 6; i++) begin
      send_item(make_item(smpt_pkg::OP_CLEAR_SHORT,
                          short_hist[$urandom_range(short_hist.size() - 1)],
                          64'd0, smpt_pkg::SRC_NONE));
      send_item(make_item(smpt_pkg::OP_CLEAR_EXT, 16'h0,
                          ext_hist[$urandom_range(ext_hist.size() - 1)],
                          smpt_pkg::SRC_NONE));
    end
  endtask

  task automatic test_random_traffic(input int count, input logic [15:0] pan,
                                     input logic en, input int idle, input int stall);
    set_config(pan, en);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) send_item(random_item());
    idle_pct  = 29;
    stall_pct = 29;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_ops();
    test_fill_tables();
    test_random_traffic(130, 16'($urandom), 1'b1, 29, 29);
    test_random_traffic(90, 16'hFFFF, 1'b1, 29, 29);
    test_random_traffic(50, 16'($urandom), 1'b0, 29, 29);
    // long stretch with both sides always ready
    test_random_traffic(110, 16'h0000, 1'b1, 0, 0);
    test_random_traffic(90, 16'($urandom), 1'b1, 29, 29);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", answer_q.size()));

    $display("run: %0d commands, %0d results checked, %0d table-full, %0d not-found",
             items_sent, results_seen, n_full, n_not_found);
    $display("run: %0d pending answers (%0d from table hits), %0d mismatches",
             n_pending, n_hits, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
